@@ rtl/pss_pkg.sv @@
`default_nettype none

package pss_pkg;

    localparam int NUM_ENTRIES = 256;
    localparam logic [15:0] TICK_MS = 16'd10;
    localparam logic [15:0] HB_TIMEOUT_RESET = 16'd3000;
    localparam logic [15:0] STATUS_PERIOD_RESET = 16'd1000;

    // input opcodes
    localparam logic [1:0] OP_TICK      = 2'd0;
    localparam logic [1:0] OP_REQUEST   = 2'd1;
    localparam logic [1:0] OP_HEARTBEAT = 2'd2;
    localparam logic [1:0] OP_UNUSED    = 2'd3;

    // result kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_STATUS = 2'd1;
    localparam logic [1:0] KIND_VAR    = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

    // register indexes
    localparam logic REG_HB_TIMEOUT    = 1'b0;
    localparam logic REG_STATUS_PERIOD = 1'b1;

    typedef enum logic [1:0] {
        SCAN_SERVE,
        SCAN_MATCH,
        SCAN_FREE
    } pss_scan_mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_SERVE,
        ST_EMIT2,
        ST_MATCH,
        ST_FREE
    } pss_state_t;

    // broadcast from the sequencer to every cell
    typedef struct packed {
        logic           tick_add;
        pss_scan_mode_t mode;
        logic [15:0]    cmd_id;
        logic [15:0]    cmd_per;
    } pss_cell_ctl_t;

    // token handed from cell to cell along the row
    typedef struct packed {
        logic        valid;
        logic        hit;
        logic [15:0] id;
    } pss_carry_t;

endpackage

`default_nettype wire

@@ rtl/periodic_scan_scheduler.sv @@
`default_nettype none

// Periodic scan scheduler. The slot table lives in a row of NUM_ENTRIES cells;
// every table operation sends a token down the row, one cell per clock, so the
// row length sets the timing. A heartbeat or unused opcode gives its result the
// cycle after start. A tick ages the heartbeat and status counters, bumps all
// timers and sweeps the row, and gives a status result and a variable result
// in turn when both are due. A read request sweeps the row once when the id is
// already in the table or the period is 0, and a second time when a free slot
// must be found. busy is high from the accepting edge until the final result is
// driven, and a heartbeat or unused opcode never raises it; start is taken
// only while busy is low. Results come out on result_strobe, one per cycle,
// back to back when an input gives two, with last marking the final one;
// there is no backpressure, so the receiver must take every beat as it appears.
module periodic_scan_scheduler #(
    parameter int NUM_ENTRIES = pss_pkg::NUM_ENTRIES
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // command channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  opcode,
    input  wire logic [15:0] var_id,
    input  wire logic [15:0] period,
    // result channel
    output logic             result_strobe,
    output logic [1:0]       kind,
    output logic [15:0]      send_id,
    output logic             connected,
    output logic             last,
    // configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    pss_pkg::pss_state_t     state_reg;
    pss_pkg::pss_state_t     state_next;
    pss_pkg::pss_scan_mode_t mode_reg;
    pss_pkg::pss_scan_mode_t mode_next;
    logic [15:0]             cmd_id_reg;
    logic [15:0]             cmd_id_next;
    logic [15:0]             cmd_per_reg;
    logic [15:0]             cmd_per_next;
    logic                    launch_reg;
    logic                    launch_next;
    logic                    tick_add;
    logic                    status_due_reg;
    logic                    status_due_next;

    logic [15:0]             hb_age_reg;
    logic [15:0]             hb_age_next;
    logic                    connected_reg;
    logic                    connected_next;
    logic [15:0]             status_age_reg;
    logic [15:0]             status_age_next;
    logic [15:0]             hb_timeout_reg;
    logic [15:0]             status_period_reg;

    logic                    strobe_reg;
    logic                    strobe_next;
    logic [1:0]              kind_reg;
    logic [1:0]              kind_next;
    logic [15:0]             send_id_reg;
    logic [15:0]             send_id_next;
    logic                    last_reg;
    logic                    last_next;

    logic                    accept;
    logic                    cfg_write;
    logic [15:0]             hb_age_inc;
    logic [15:0]             status_age_inc;

    pss_pkg::pss_cell_ctl_t  ctl;
    pss_pkg::pss_carry_t     carry [NUM_ENTRIES+1];
    pss_pkg::pss_carry_t     tail;

    assign accept    = start && (state_reg == pss_pkg::ST_IDLE);
    assign cfg_write = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hb_timeout_reg    <= pss_pkg::HB_TIMEOUT_RESET;
            status_period_reg <= pss_pkg::STATUS_PERIOD_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == pss_pkg::REG_HB_TIMEOUT)
            begin
                hb_timeout_reg <= pwdata[15:0];
            end
            else
            begin
                status_period_reg <= pwdata[15:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == pss_pkg::REG_STATUS_PERIOD) ? {16'd0, status_period_reg}
                                                             : {16'd0, hb_timeout_reg};

    // broadcast to the cell row
    assign ctl.tick_add = tick_add;
    assign ctl.mode     = mode_reg;
    assign ctl.cmd_id   = cmd_id_reg;
    assign ctl.cmd_per  = cmd_per_reg;

    assign carry[0].valid = launch_reg;
    assign carry[0].hit   = 1'b0;
    assign carry[0].id    = 16'd0;

    genvar gi;
    generate
        for (gi = 0; gi < NUM_ENTRIES; gi++)
        begin : g_cell
            pss_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctl      (ctl),
                .carry_in (carry[gi]),
                .carry_out(carry[gi+1])
            );
        end
    endgenerate

    assign tail = carry[NUM_ENTRIES];

    assign hb_age_inc     = hb_age_reg + pss_pkg::TICK_MS;
    assign status_age_inc = status_age_reg + pss_pkg::TICK_MS;

    // sequencer: launch sweeps and emit results
    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        cmd_id_next     = cmd_id_reg;
        cmd_per_next    = cmd_per_reg;
        launch_next     = 1'b0;
        tick_add        = 1'b0;
        status_due_next = status_due_reg;
        hb_age_next     = hb_age_reg;
        connected_next  = connected_reg;
        status_age_next = status_age_reg;
        strobe_next     = 1'b0;
        kind_next       = kind_reg;
        send_id_next    = send_id_reg;
        last_next       = last_reg;

        case (state_reg)
            pss_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cmd_id_next  = var_id;
                    cmd_per_next = period;
                    case (opcode)
                        pss_pkg::OP_TICK:
                        begin
                            state_next = pss_pkg::ST_TICK;
                        end
                        pss_pkg::OP_REQUEST:
                        begin
                            mode_next   = pss_pkg::SCAN_MATCH;
                            launch_next = 1'b1;
                            state_next  = pss_pkg::ST_MATCH;
                        end
                        pss_pkg::OP_HEARTBEAT:
                        begin
                            connected_next = 1'b1;
                            hb_age_next    = 16'd0;
                            strobe_next    = 1'b1;
                            kind_next      = pss_pkg::KIND_NONE;
                            send_id_next   = 16'd0;
                            last_next      = 1'b1;
                        end
                        default:
                        begin
                            strobe_next  = 1'b1;
                            kind_next    = pss_pkg::KIND_NONE;
                            send_id_next = 16'd0;
                            last_next    = 1'b1;
                        end
                    endcase
                end
            end
            pss_pkg::ST_TICK:
            begin
                // age heartbeat and status, bump all timers, then sweep
                hb_age_next = hb_age_inc;
                if (hb_age_inc > hb_timeout_reg)
                begin
                    connected_next = 1'b0;
                end
                if (status_age_inc > status_period_reg)
                begin
                    status_age_next = 16'd0;
                    status_due_next = 1'b1;
                end
                else
                begin
                    status_age_next = status_age_inc;
                    status_due_next = 1'b0;
                end
                tick_add    = 1'b1;
                mode_next   = pss_pkg::SCAN_SERVE;
                launch_next = 1'b1;
                state_next  = pss_pkg::ST_SERVE;
            end
            pss_pkg::ST_SERVE:
            begin
                if (tail.valid)
                begin
                    strobe_next = 1'b1;
                    cmd_id_next = tail.id;
                    if (status_due_reg)
                    begin
                        kind_next    = pss_pkg::KIND_STATUS;
                        send_id_next = 16'd0;
                        last_next    = !tail.hit;
                        state_next   = tail.hit ? pss_pkg::ST_EMIT2 : pss_pkg::ST_IDLE;
                    end
                    else if (tail.hit)
                    begin
                        kind_next    = pss_pkg::KIND_VAR;
                        send_id_next = tail.id;
                        last_next    = 1'b1;
                        state_next   = pss_pkg::ST_IDLE;
                    end
                    else
                    begin
                        kind_next    = pss_pkg::KIND_NONE;
                        send_id_next = 16'd0;
                        last_next    = 1'b1;
                        state_next   = pss_pkg::ST_IDLE;
                    end
                end
            end
            pss_pkg::ST_EMIT2:
            begin
                strobe_next  = 1'b1;
                kind_next    = pss_pkg::KIND_VAR;
                send_id_next = cmd_id_reg;
                last_next    = 1'b1;
                state_next   = pss_pkg::ST_IDLE;
            end
            pss_pkg::ST_MATCH:
            begin
                if (tail.valid)
                begin
                    if (!tail.hit && (cmd_per_reg != 16'd0))
                    begin
                        mode_next   = pss_pkg::SCAN_FREE;
                        launch_next = 1'b1;
                        state_next  = pss_pkg::ST_FREE;
                    end
                    else
                    begin
                        strobe_next  = 1'b1;
                        kind_next    = pss_pkg::KIND_READ;
                        send_id_next = cmd_id_reg;
                        last_next    = 1'b1;
                        state_next   = pss_pkg::ST_IDLE;
                    end
                end
            end
            pss_pkg::ST_FREE:
            begin
                if (tail.valid)
                begin
                    strobe_next  = 1'b1;
                    kind_next    = pss_pkg::KIND_READ;
                    send_id_next = cmd_id_reg;
                    last_next    = 1'b1;
                    state_next   = pss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pss_pkg::ST_IDLE;
            mode_reg       <= pss_pkg::SCAN_SERVE;
            launch_reg     <= 1'b0;
            status_due_reg <= 1'b0;
            hb_age_reg     <= 16'd0;
            connected_reg  <= 1'b0;
            status_age_reg <= 16'd0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            launch_reg     <= launch_next;
            status_due_reg <= status_due_next;
            hb_age_reg     <= hb_age_next;
            connected_reg  <= connected_next;
            status_age_reg <= status_age_next;
            strobe_reg     <= strobe_next;
        end
    end

    // hold command and result payload
    always_ff @(posedge clk)
    begin
        cmd_id_reg  <= cmd_id_next;
        cmd_per_reg <= cmd_per_next;
        kind_reg    <= kind_next;
        send_id_reg <= send_id_next;
        last_reg    <= last_next;
    end

    assign busy          = (state_reg != pss_pkg::ST_IDLE);
    assign result_strobe = strobe_reg;
    assign kind          = kind_reg;
    assign send_id       = send_id_reg;
    assign connected     = connected_reg;
    assign last          = last_reg;

endmodule

`default_nettype wire

@@ rtl/pss_cell.sv @@
`default_nettype none

module pss_cell (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire pss_pkg::pss_cell_ctl_t ctl,
    input  wire pss_pkg::pss_carry_t    carry_in,
    output pss_pkg::pss_carry_t         carry_out
);

    logic               enable_reg;
    logic               enable_next;
    logic [15:0]        id_reg;
    logic [15:0]        id_next;
    logic [15:0]        period_reg;
    logic [15:0]        period_next;
    logic [15:0]        timer_reg;
    logic [15:0]        timer_next;
    pss_pkg::pss_carry_t carry_reg;
    pss_pkg::pss_carry_t carry_next;
    logic               act;

    // act on the token when it is live and not yet taken
    always_comb
    begin
        enable_next = enable_reg;
        id_next     = id_reg;
        period_next = period_reg;
        timer_next  = timer_reg;
        act         = 1'b0;

        if (ctl.tick_add)
        begin
            timer_next = timer_reg + pss_pkg::TICK_MS;
        end

        if (carry_in.valid && !carry_in.hit)
        begin
            case (ctl.mode)
                pss_pkg::SCAN_SERVE:
                begin
                    if (enable_reg && (period_reg != 16'd0) && (timer_reg >= period_reg))
                    begin
                        act        = 1'b1;
                        timer_next = 16'd0;
                    end
                end
                pss_pkg::SCAN_MATCH:
                begin
                    if (id_reg == ctl.cmd_id)
                    begin
                        if (ctl.cmd_per != 16'd0)
                        begin
                            period_next = ctl.cmd_per;
                            enable_next = 1'b1;
                            act         = 1'b1;
                        end
                        else
                        begin
                            period_next = 16'd0;
                            enable_next = 1'b0;
                        end
                    end
                end
                pss_pkg::SCAN_FREE:
                begin
                    if (!enable_reg)
                    begin
                        id_next     = ctl.cmd_id;
                        period_next = ctl.cmd_per;
                        enable_next = 1'b1;
                        act         = 1'b1;
                    end
                end
                default:
                begin
                    act = 1'b0;
                end
            endcase
        end

        // pass the token on, stamped with this slot's id when taken here
        carry_next.valid = carry_in.valid;
        carry_next.hit   = carry_in.hit | act;
        carry_next.id    = act ? id_reg : carry_in.id;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            id_reg     <= 16'd0;
            period_reg <= 16'd0;
            timer_reg  <= 16'd0;
            carry_reg  <= '0;
        end
        else
        begin
            enable_reg <= enable_next;
            id_reg     <= id_next;
            period_reg <= period_next;
            timer_reg  <= timer_next;
            carry_reg  <= carry_next;
        end
    end

    assign carry_out = carry_reg;

endmodule

`default_nettype wire

@@ rtl/pss_checker.sv @@
`default_nettype none

module pss_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [1:0]  opcode,
    input wire logic        result_strobe,
    input wire logic [1:0]  kind,
    input wire logic        connected,
    input wire logic        last
);

    // the second result of a tick follows in the very next cycle
    a_second_beat: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last |=> result_strobe && last)
        else $error("second result beat missing");

    // only a status beat can be followed by another beat
    a_first_is_status: assert property (@(posedge clk) disable iff (!rst_n)
        result_strobe && !last |-> kind == pss_pkg::KIND_STATUS)
        else $error("non-final beat is not a status report");

    // an accepted request keeps the block busy while the row is swept
    a_request_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && opcode == pss_pkg::OP_REQUEST |=> busy && !result_strobe)
        else $error("request did not start a sweep");

    // the host turns connected only after an accepted heartbeat
    a_connect_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(connected) |-> $past(start && !busy && opcode == pss_pkg::OP_HEARTBEAT))
        else $error("connected rose without heartbeat");

endmodule

bind periodic_scan_scheduler pss_checker u_pss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .result_strobe(result_strobe),
    .kind         (kind),
    .connected    (connected),
    .last         (last)
);

`default_nettype wire
